FILE: design/mcwe_pkg.sv
// Shared types, constants and saturation helpers for the weight envelope core.
package mcwe_pkg;

    localparam int CHAN_W = 4;
    localparam int W_W = 24;
    localparam int FR_W = 16;
    localparam int LIM_W = 8;
    localparam int FC_W = 32;
    localparam int CFG_IDX_W = 2;
    localparam int DEF_NUM_CHANNELS = 8;
    localparam int QDEPTH = 2;

    typedef logic signed [W_W-1:0] t_weight;
    typedef logic signed [W_W:0] t_wide;
    typedef logic signed [FR_W+1:0] t_den;

    typedef enum logic [2:0] {
        OP_TICK,
        OP_RAMP_FRAMES,
        OP_ACCEL,
        OP_RAMP_STEP,
        OP_PINGPONG,
        OP_TRIANGLE,
        OP_STOP
    } t_op;

    typedef struct packed {
        t_op                op;
        logic [CHAN_W-1:0]  ch;
        t_weight            target;
        t_weight            velo;
        t_weight            acc;
        logic [FR_W-1:0]    spend;
        logic [FR_W-1:0]    attack;
        logic [FR_W-1:0]    rest;
        logic [LIM_W-1:0]   limit;
    } t_cmd;

    typedef struct packed {
        t_wide num;
        t_den  den;
    } t_div_req;

    localparam t_wide W_MAX_WIDE = 25'sd8388607;
    localparam t_wide W_MIN_WIDE = -25'sd8388608;

    function automatic t_weight sat_wide(input t_wide s);
        t_weight r;
        if (s > W_MAX_WIDE) begin
            r = 24'sh7fffff;
        end else if (s < W_MIN_WIDE) begin
            r = 24'sh800000;
        end else begin
            r = s[W_W-1:0];
        end
        return r;
    endfunction

    function automatic t_weight sat_add(input t_weight a, input t_weight b);
        t_wide s;
        s = {a[W_W-1], a} + {b[W_W-1], b};
        return sat_wide(s);
    endfunction

    function automatic t_weight sat_neg(input t_weight a);
        t_wide s;
        s = t_wide'(0) - {a[W_W-1], a};
        return sat_wide(s);
    endfunction

    function automatic t_wide wdiff(input t_weight a, input t_weight b);
        return {a[W_W-1], a} - {b[W_W-1], b};
    endfunction

endpackage

FILE: design/mcwe_ifaces.sv
// Channel interfaces: requests, results and configuration writes.
interface mcwe_req_if;
    logic                          valid;
    logic                          ready;
    logic [2:0]                    req_type;
    logic [mcwe_pkg::CHAN_W-1:0]   channel;
    logic signed [mcwe_pkg::W_W-1:0] target_weight;
    logic signed [mcwe_pkg::W_W-1:0] step_velocity;
    logic signed [mcwe_pkg::W_W-1:0] step_accel;
    logic [mcwe_pkg::FR_W-1:0]     spend_frames;
    logic [mcwe_pkg::FR_W-1:0]     attack_frames;
    logic [mcwe_pkg::FR_W-1:0]     rest_frames;
    logic [mcwe_pkg::LIM_W-1:0]    halfloop_limit;

    modport source(output valid, req_type, channel, target_weight, step_velocity, step_accel,
                   spend_frames, attack_frames, rest_frames, halfloop_limit, input ready);
    modport sink(input valid, req_type, channel, target_weight, step_velocity, step_accel,
                 spend_frames, attack_frames, rest_frames, halfloop_limit, output ready);
endinterface

interface mcwe_res_if;
    logic                          valid;
    logic                          ready;
    logic [mcwe_pkg::CHAN_W-1:0]   out_channel;
    logic signed [mcwe_pkg::W_W-1:0] weight;
    logic                          last;

    modport source(output valid, out_channel, weight, last, input ready);
    modport sink(input valid, out_channel, weight, last, output ready);
endinterface

interface mcwe_cfg_if;
    logic                             valid;
    logic                             ready;
    logic [mcwe_pkg::CFG_IDX_W-1:0]   index;
    logic [mcwe_pkg::W_W-1:0]         data;

    modport source(output valid, index, data, input ready);
    modport sink(input valid, index, data, output ready);
endinterface

FILE: design/mcwe_front.sv
// Front end: accepts request items, decodes and filters them, queues commands.
module mcwe_front #(
    parameter int NUM_CHANNELS = mcwe_pkg::DEF_NUM_CHANNELS
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    mcwe_req_if.sink        i_req,
    output logic            o_q_valid,
    output mcwe_pkg::t_cmd  o_q_cmd,
    input  logic            i_q_pop
);
    import mcwe_pkg::*;

    localparam int QA_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam logic [2:0] REQ_TICK     = 3'd0;
    localparam logic [2:0] REQ_RAMP_FR  = 3'd1;
    localparam logic [2:0] REQ_ACCEL    = 3'd2;
    localparam logic [2:0] REQ_RAMP_ST  = 3'd3;
    localparam logic [2:0] REQ_PINGPONG = 3'd4;
    localparam logic [2:0] REQ_TRIANGLE = 3'd5;
    localparam logic [2:0] REQ_STOP     = 3'd6;

    t_cmd              r_q [QDEPTH];
    logic [QA_W-1:0]   r_wptr, n_wptr;
    logic [QA_W-1:0]   r_rptr, n_rptr;
    logic [QA_W:0]     r_count, n_count;
    t_cmd              dec_cmd;
    logic              dec_keep;
    logic              chan_ok;
    logic              push;
    logic              pop;

    assign chan_ok = (i_req.channel != '0) &&
                     ({28'd0, i_req.channel} <= 32'(NUM_CHANNELS));

    always_comb begin
        dec_cmd.ch     = i_req.channel;
        dec_cmd.target = i_req.target_weight;
        dec_cmd.velo   = i_req.step_velocity;
        dec_cmd.acc    = i_req.step_accel;
        dec_cmd.spend  = i_req.spend_frames;
        dec_cmd.attack = i_req.attack_frames;
        dec_cmd.rest   = i_req.rest_frames;
        dec_cmd.limit  = i_req.halfloop_limit;
        dec_cmd.op     = OP_TICK;
        dec_keep       = chan_ok;
        unique case (i_req.req_type)
            REQ_TICK: begin
                dec_cmd.op = OP_TICK;
                dec_keep   = 1'b1;
            end
            REQ_RAMP_FR:  dec_cmd.op = OP_RAMP_FRAMES;
            REQ_ACCEL:    dec_cmd.op = OP_ACCEL;
            REQ_RAMP_ST:  dec_cmd.op = OP_RAMP_STEP;
            REQ_PINGPONG: dec_cmd.op = OP_PINGPONG;
            REQ_TRIANGLE: dec_cmd.op = OP_TRIANGLE;
            REQ_STOP:     dec_cmd.op = OP_STOP;
            default:      dec_keep   = 1'b0;
        endcase
    end

    assign i_req.ready = (r_count < (QA_W+1)'(QDEPTH));
    assign push        = i_req.valid && i_req.ready && dec_keep;
    assign pop         = i_q_pop && (r_count != '0);
    assign o_q_valid   = (r_count != '0);
    assign o_q_cmd     = r_q[r_rptr];

    always_comb begin
        n_wptr  = push ? r_wptr + 1'b1 : r_wptr;
        n_rptr  = pop ? r_rptr + 1'b1 : r_rptr;
        n_count = r_count + (QA_W+1)'(push) - (QA_W+1)'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wptr] <= dec_cmd;
        end
    end

endmodule

FILE: design/mcwe_div.sv
// Restoring divider, one quotient bit per cycle, saturated signed quotient.
module mcwe_div (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  mcwe_pkg::t_div_req i_req,
    output logic               o_done,
    output mcwe_pkg::t_weight  o_quot
);
    import mcwe_pkg::*;

    localparam int QW = W_W + 1;
    localparam int CNT_W = $clog2(QW);

    logic              r_busy;
    logic              r_done;
    logic              r_zero;
    logic              r_neg;
    logic [CNT_W-1:0]  r_cnt;
    logic [FR_W:0]     r_rem;
    logic [QW-1:0]     r_quo;
    logic [FR_W-1:0]   r_den;
    logic [FR_W:0]     rem_sh;
    logic              ge;
    logic [QW-1:0]     mag;
    logic [QW-1:0]     neg_quo;

    assign mag    = i_req.num[QW-1] ? (~i_req.num + 1'b1) : i_req.num;
    assign rem_sh = {r_rem[FR_W-1:0], r_quo[QW-1]};
    assign ge     = (rem_sh >= {1'b0, r_den});
    assign neg_quo = ~r_quo + 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                if (i_req.den <= 0) begin
                    r_done <= 1'b1;
                    r_busy <= 1'b0;
                end else begin
                    r_busy <= 1'b1;
                end
            end else if (r_busy && (r_cnt == '0)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_zero <= (i_req.den <= 0);
            r_neg  <= i_req.num[QW-1];
            r_quo  <= mag;
            r_rem  <= '0;
            r_den  <= i_req.den[FR_W-1:0];
            r_cnt  <= CNT_W'(QW - 1);
        end else if (r_busy) begin
            r_rem <= ge ? (rem_sh - {1'b0, r_den}) : rem_sh;
            r_quo <= {r_quo[QW-2:0], ge};
            r_cnt <= r_cnt - 1'b1;
        end
    end

    always_comb begin
        if (r_zero) begin
            o_quot = '0;
        end else if (!r_neg) begin
            o_quot = (r_quo > QW'(24'h7fffff)) ? 24'sh7fffff : r_quo[W_W-1:0];
        end else begin
            o_quot = (r_quo > QW'(24'h800000)) ? 24'sh800000 : neg_quo[W_W-1:0];
        end
    end

    assign o_done = r_done;

endmodule

FILE: design/mcwe_back.sv
// Back end: channel state, command execution, tick walk and result register.
module mcwe_back #(
    parameter int NUM_CHANNELS = mcwe_pkg::DEF_NUM_CHANNELS
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_q_valid,
    input  mcwe_pkg::t_cmd  i_q_cmd,
    output logic            o_q_pop,
    mcwe_cfg_if.sink        i_cfg,
    mcwe_res_if.source      o_res
);
    import mcwe_pkg::*;

    localparam int IDX_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
    localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TOP    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BOTTOM = 2'd2;
    localparam t_wide ONE_Q16 = 25'sd65536;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CMD,
        S_ADV,
        S_DIVW,
        S_EMIT
    } t_state;

    typedef enum logic [2:0] {
        M_IDLE,
        M_LINEAR,
        M_ACCEL,
        M_PINGPONG,
        M_TRIANGLE
    } t_mode;

    t_weight           r_w     [NUM_CHANNELS];
    t_weight           r_v     [NUM_CHANNELS];
    t_weight           r_a     [NUM_CHANNELS];
    t_weight           r_tgt   [NUM_CHANNELS];
    t_mode             r_mode  [NUM_CHANNELS];
    logic [LIM_W-1:0]  r_hcnt  [NUM_CHANNELS];
    logic [LIM_W-1:0]  r_hstop [NUM_CHANNELS];
    logic [FR_W-1:0]   r_att   [NUM_CHANNELS];
    logic [FR_W-1:0]   r_rest  [NUM_CHANNELS];
    logic [FR_W-1:0]   r_per   [NUM_CHANNELS];
    logic [FC_W-1:0]   r_start [NUM_CHANNELS];
    logic [FC_W-1:0]   r_fc;
    logic [CHAN_W-1:0] r_act;
    t_weight           r_top;
    t_weight           r_bot;

    t_state            r_state;
    t_state            r_ret;
    t_cmd              r_cmd;
    logic [CHAN_W-1:0] r_chan;
    logic              r_ov;
    logic [CHAN_W-1:0] r_och;
    t_weight           r_ow;
    logic              r_olast;
    logic              r_dstart;
    t_div_req          r_dreq;

    logic              div_done;
    t_weight           div_quot;
    logic [IDX_W-1:0]  idx;
    logic              in_range;
    t_weight           cw, cv, ct, w1;
    logic              clamp;
    logic              tri_a, tri_p;
    logic [LIM_W-1:0]  hc1;
    logic              hit;
    logic              out_free;
    logic              is_last;
    logic              cmd_div;
    logic              adv_div;

    mcwe_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_dstart),
        .i_req   (r_dreq),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    assign idx      = IDX_W'(r_chan - 1'b1);
    assign in_range = ({28'd0, r_chan} <= 32'(NUM_CHANNELS));
    assign cw       = r_w[idx];
    assign cv       = r_v[idx];
    assign ct       = r_tgt[idx];
    assign w1       = sat_add(cw, cv);
    assign clamp    = ((cv > 0) && (ct < w1)) || ((cv < 0) && (ct > w1));
    assign tri_a    = ((r_start[idx] + {16'd0, r_att[idx]}) == r_fc);
    assign tri_p    = ((r_start[idx] + {16'd0, r_per[idx]}) == r_fc);
    assign hc1      = r_hcnt[idx] + 1'b1;
    assign hit      = (r_hstop[idx] != '0) && (hc1 == r_hstop[idx]);
    assign out_free = !r_ov || o_res.ready;
    assign is_last  = (r_chan == r_act);
    assign cmd_div  = (r_cmd.op == OP_RAMP_FRAMES) || (r_cmd.op == OP_PINGPONG) ||
                      (r_cmd.op == OP_TRIANGLE);
    assign adv_div  = in_range && (r_mode[idx] == M_TRIANGLE) &&
                      (tri_a || (!(r_bot > w1) && tri_p));

    assign o_q_pop         = (r_state == S_IDLE);
    assign i_cfg.ready     = 1'b1;
    assign o_res.valid     = r_ov;
    assign o_res.out_channel = r_och;
    assign o_res.weight    = r_ow;
    assign o_res.last      = r_olast;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ret    <= S_IDLE;
            r_ov     <= 1'b0;
            r_dstart <= 1'b0;
            r_fc     <= '0;
            r_act    <= 4'd8;
            r_top    <= 24'sd65536;
            r_bot    <= '0;
            for (int i = 0; i < NUM_CHANNELS; i++) begin
                r_w[i]     <= '0;
                r_v[i]     <= '0;
                r_a[i]     <= '0;
                r_tgt[i]   <= '0;
                r_mode[i]  <= M_IDLE;
                r_hcnt[i]  <= '0;
                r_hstop[i] <= '0;
                r_att[i]   <= '0;
                r_rest[i]  <= '0;
                r_per[i]   <= '0;
                r_start[i] <= '0;
            end
        end else begin
            r_dstart <= ((r_state == S_CMD) && cmd_div) || ((r_state == S_ADV) && adv_div);
            if (r_ov && o_res.ready && (r_state != S_EMIT)) begin
                r_ov <= 1'b0;
            end
            if (i_cfg.valid) begin
                unique case (i_cfg.index)
                    CFG_ACTIVE: r_act <= i_cfg.data[CHAN_W-1:0];
                    CFG_TOP:    r_top <= i_cfg.data;
                    CFG_BOTTOM: r_bot <= i_cfg.data;
                    default: ;
                endcase
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_q_valid) begin
                        r_cmd <= i_q_cmd;
                        if (i_q_cmd.op == OP_TICK) begin
                            r_chan <= 4'd1;
                            if (r_act == '0) begin
                                r_fc <= r_fc + 1'b1;
                            end else begin
                                r_state <= S_ADV;
                            end
                        end else begin
                            r_chan  <= i_q_cmd.ch;
                            r_state <= S_CMD;
                        end
                    end
                end
                S_CMD: begin
                    r_state <= cmd_div ? S_DIVW : S_IDLE;
                    r_ret   <= S_IDLE;
                    case (r_cmd.op)
                        OP_RAMP_FRAMES: begin
                            r_mode[idx]  <= M_LINEAR;
                            r_tgt[idx]   <= r_cmd.target;
                            r_dreq.num   <= wdiff(r_cmd.target, cw);
                            r_dreq.den   <= {2'b0, r_cmd.spend};
                        end
                        OP_ACCEL: begin
                            r_mode[idx] <= M_ACCEL;
                            r_tgt[idx]  <= r_cmd.target;
                            r_v[idx]    <= r_cmd.velo;
                            r_a[idx]    <= r_cmd.acc;
                        end
                        OP_RAMP_STEP: begin
                            r_mode[idx] <= M_LINEAR;
                            r_tgt[idx]  <= r_cmd.target;
                            if (r_cmd.target > cw) begin
                                r_v[idx] <= r_cmd.velo;
                            end else if (r_cmd.target < cw) begin
                                r_v[idx] <= sat_neg(r_cmd.velo);
                            end else begin
                                r_v[idx] <= '0;
                            end
                        end
                        OP_PINGPONG: begin
                            r_mode[idx]  <= M_PINGPONG;
                            r_hcnt[idx]  <= '0;
                            r_hstop[idx] <= r_cmd.limit;
                            r_dreq.num   <= ONE_Q16;
                            r_dreq.den   <= {3'b0, r_cmd.spend[FR_W-1:1]};
                        end
                        OP_TRIANGLE: begin
                            r_mode[idx]  <= M_TRIANGLE;
                            r_hcnt[idx]  <= '0;
                            r_hstop[idx] <= r_cmd.limit;
                            r_att[idx]   <= r_cmd.attack;
                            r_rest[idx]  <= r_cmd.rest;
                            r_per[idx]   <= r_cmd.spend;
                            r_start[idx] <= r_fc;
                            r_dreq.num   <= wdiff(r_top, cw);
                            r_dreq.den   <= {2'b0, r_cmd.attack};
                        end
                        OP_STOP: r_mode[idx] <= M_IDLE;
                        default: ;
                    endcase
                end
                S_ADV: begin
                    r_state <= adv_div ? S_DIVW : S_EMIT;
                    r_ret   <= S_EMIT;
                    if (in_range) begin
                        case (r_mode[idx])
                            M_LINEAR, M_ACCEL: begin
                                r_w[idx] <= clamp ? ct : w1;
                                if (clamp) begin
                                    r_mode[idx] <= M_IDLE;
                                end
                                if (r_mode[idx] == M_ACCEL) begin
                                    r_v[idx] <= sat_add(cv, r_a[idx]);
                                end
                            end
                            M_PINGPONG: begin
                                if ((r_top < w1) || (r_bot > w1)) begin
                                    r_w[idx]    <= (r_top < w1) ? r_top : r_bot;
                                    r_v[idx]    <= sat_neg(cv);
                                    r_hcnt[idx] <= hc1;
                                    if (hit) begin
                                        r_mode[idx] <= M_IDLE;
                                    end
                                end else begin
                                    r_w[idx] <= w1;
                                end
                            end
                            M_TRIANGLE: begin
                                if (tri_a) begin
                                    r_w[idx]    <= r_top;
                                    r_dreq.num  <= wdiff(r_bot, r_top);
                                    r_dreq.den  <= {2'b0, r_per[idx]} - {2'b0, r_att[idx]}
                                                   - {2'b0, r_rest[idx]};
                                    r_hcnt[idx] <= hc1;
                                    if (hit) begin
                                        r_mode[idx] <= M_IDLE;
                                    end
                                end else if (r_bot > w1) begin
                                    r_w[idx] <= r_bot;
                                    r_v[idx] <= '0;
                                end else if (tri_p) begin
                                    r_w[idx]     <= w1;
                                    r_start[idx] <= r_fc;
                                    r_dreq.num   <= wdiff(r_top, r_bot);
                                    r_dreq.den   <= {2'b0, r_att[idx]};
                                    r_hcnt[idx]  <= hc1;
                                    if (hit) begin
                                        r_mode[idx] <= M_IDLE;
                                    end
                                end else begin
                                    r_w[idx] <= w1;
                                end
                            end
                            default: ;
                        endcase
                    end
                end
                S_DIVW: begin
                    if (div_done) begin
                        r_v[idx] <= div_quot;
                        r_state  <= r_ret;
                    end
                end
                S_EMIT: begin
                    if (out_free) begin
                        r_ov    <= 1'b1;
                        r_och   <= r_chan;
                        r_ow    <= in_range ? cw : '0;
                        r_olast <= is_last;
                        if (is_last) begin
                            r_fc    <= r_fc + 1'b1;
                            r_state <= S_IDLE;
                        end else begin
                            r_chan  <= r_chan + 1'b1;
                            r_state <= S_ADV;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

`ifndef SYNTHESIS
    a_load_from_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_ov) |-> $past(r_state == S_EMIT))
        else $error("result register loaded outside the emit step");
    a_walk_chan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ADV || r_state == S_EMIT) |-> (r_chan != '0))
        else $error("tick walk on channel zero");
    a_frame_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && (r_fc != $past(r_fc))) |-> (r_fc == $past(r_fc) + 1'b1))
        else $error("frame counter jumped");
`endif

endmodule

FILE: design/multi_channel_weight_envelope_core.sv
// Top level of the multi-channel weight envelope core.
// Channels: i_req takes request items (tick, ramp, loop and stop commands),
// o_res returns one item per walked channel on each tick, with last set on the
// final one, and i_cfg writes active_channels, top_weight and bottom_weight.
// Accepted requests pass through a two-entry queue to the execution engine.
// A command that starts a ramp by frames, a ping-pong or a triangle loop waits
// on the 25-step bit-serial divider. A tick walks every active channel, and
// each triangle channel that turns at a phase edge waits on the divider again.
// After a tick is taken, the first channel passes its advance step (and any
// divide), then its emit step loads the first result of the tick.
// A stalled o_res holds the result register; the walk waits, the queue fills
// and then i_req.ready drops. Results are never lost or repeated.
// Reset (i_rst_n low, synchronous) idles every channel, clears weights and
// the frame counter, and restores the register defaults (8, 1.0, 0.0).
module multi_channel_weight_envelope_core #(
    parameter int NUM_CHANNELS = mcwe_pkg::DEF_NUM_CHANNELS
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    mcwe_req_if.sink   i_req,
    mcwe_cfg_if.sink   i_cfg,
    mcwe_res_if.source o_res
);
    import mcwe_pkg::*;

    logic q_valid;
    t_cmd q_cmd;
    logic q_pop;

    mcwe_front #(
        .NUM_CHANNELS (NUM_CHANNELS)
    ) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (i_req),
        .o_q_valid (q_valid),
        .o_q_cmd   (q_cmd),
        .i_q_pop   (q_pop)
    );

    mcwe_back #(
        .NUM_CHANNELS (NUM_CHANNELS)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_q_cmd   (q_cmd),
        .o_q_pop   (q_pop),
        .i_cfg     (i_cfg),
        .o_res     (o_res)
    );

endmodule
